FILE: design/ffcb_pkg.sv
package ffcb_pkg;

	localparam int HEADER_BYTES_DEF = 4;
	localparam int POS_W = 9;
	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [8:0] FLETCHER_MOD = 9'd255;

	typedef enum logic {
		CMD_CHECK = 1'b0,
		CMD_BUILD = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_CHECKSUM_OFFSET = 1'b0,
		REG_PAYLOAD_LENGTH  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic        match;
		logic [15:0] checksum;
		logic [7:0]  sequence_number;
		logic [7:0]  length_byte;
	} out_word_t;

	typedef struct packed {
		reg_idx_t    index;
		logic [15:0] data;
	} cfg_word_t;

	// one byte handed to the frame tracker
	typedef struct packed {
		logic       step;
		logic [7:0] data_byte;
		logic       last_byte;
	} step_t;

	// frame state after the byte being presented
	typedef struct packed {
		logic [7:0]       first_sum;
		logic [7:0]       second_sum;
		logic [15:0]      header_word;
		logic [POS_W-1:0] position;
	} frame_t;

	function automatic logic [7:0] mod_add(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= FLETCHER_MOD)
			s = s - FLETCHER_MOD;
		return s[7:0];
	endfunction

endpackage

FILE: design/ffcb_if.sv
interface ffcb_in_if;
	logic               valid;
	logic               ready;
	ffcb_pkg::in_word_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface ffcb_out_if;
	logic                valid;
	logic                ready;
	ffcb_pkg::out_word_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface ffcb_cfg_if;
	logic                valid;
	logic                ready;
	ffcb_pkg::cfg_word_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: design/ffcb_frame.sv
module ffcb_frame #(
	parameter int HEADER_BYTES = ffcb_pkg::HEADER_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffcb_pkg::step_t      step,
	input  logic [7:0]           payload_length,
	output ffcb_pkg::frame_t     frame_nxt
);

	localparam int LW = ffcb_pkg::POS_W + 1;

	logic [7:0]                first_q;
	logic [7:0]                second_q;
	logic [15:0]               header_q;
	logic [ffcb_pkg::POS_W-1:0] pos_q;

	logic [LW-1:0] pos_ext;
	logic [LW-1:0] limit;
	logic          in_payload;
	logic [7:0]    first_new;

	always_comb begin
		pos_ext    = {1'b0, pos_q};
		limit      = LW'(HEADER_BYTES) + LW'(payload_length);
		in_payload = (pos_ext >= LW'(HEADER_BYTES)) && (pos_q != ffcb_pkg::POS_MAX)
			&& (pos_ext < limit);
		first_new  = ffcb_pkg::mod_add(first_q, step.data_byte);

		frame_nxt.first_sum   = first_q;
		frame_nxt.second_sum  = second_q;
		frame_nxt.header_word = header_q;
		frame_nxt.position    = pos_q;
		if (pos_q == '0)
			frame_nxt.header_word[7:0] = step.data_byte;
		else if (pos_q == ffcb_pkg::POS_W'(1))
			frame_nxt.header_word[15:8] = step.data_byte;
		if (in_payload) begin
			frame_nxt.first_sum  = first_new;
			frame_nxt.second_sum = ffcb_pkg::mod_add(second_q, first_new);
		end
		if (pos_q != ffcb_pkg::POS_MAX)
			frame_nxt.position = pos_q + ffcb_pkg::POS_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
			header_q <= '0;
			pos_q    <= '0;
		end else if (step.step) begin
			if (step.last_byte) begin
				first_q  <= '0;
				second_q <= '0;
				header_q <= '0;
				pos_q    <= '0;
			end else begin
				first_q  <= frame_nxt.first_sum;
				second_q <= frame_nxt.second_sum;
				header_q <= frame_nxt.header_word;
				pos_q    <= frame_nxt.position;
			end
		end
	end

endmodule

FILE: design/frame_fletcher_check_build_top.sv
// Fletcher-16 frame check / header build.
// byte_in takes one frame word per cycle from frame byte 0, with command and last flag.
// The first HEADER_BYTES bytes are header (bytes 0-1 hold the received checksum,
// little-endian); the next payload_length bytes are summed mod 255.
// result_out gives one word per frame, after the word marked last: in check mode
// match says whether the header word equals the checksum plus offset; in build mode
// it carries checksum, sequence number and length, and the sequence count advances.
// cfg writes checksum_offset (index 0) and payload_length (index 1); always ready.
// A last word reaches result_out through the input register, then the result
// register. Throughput: one word per cycle unless a last word waits, set by the
// combinational mod-255 add pair in the frame tracker.
// Stall: while result_out is held, non-last words still flow; a last word waits in
// the input register and byte_in.ready drops until the result register frees.
// Reset clears sums, position, header word, sequence count and both valid flags.
module frame_fletcher_check_build_top #(
	parameter int HEADER_BYTES = ffcb_pkg::HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ffcb_in_if.sink     byte_in,
	ffcb_out_if.source  result_out,
	ffcb_cfg_if.sink    cfg
);

	logic                 valid_s1;
	ffcb_pkg::in_word_t   item_s1;
	logic                 out_valid_q;
	ffcb_pkg::out_word_t  out_q;
	logic [15:0]          offset_q;
	logic [7:0]           length_q;
	logic [7:0]           seq_q;

	logic                 out_free;
	logic                 fire_s1;
	ffcb_pkg::step_t      step;
	ffcb_pkg::frame_t     frame_nxt;
	logic [15:0]          csum;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			length_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.payload.index)
				ffcb_pkg::REG_CHECKSUM_OFFSET: offset_q <= cfg.payload.data;
				ffcb_pkg::REG_PAYLOAD_LENGTH:  length_q <= cfg.payload.data[7:0];
				default: ;
			endcase
		end
	end

	assign out_free      = !out_valid_q || result_out.ready;
	assign fire_s1       = valid_s1 && (!item_s1.last_byte || out_free);
	assign byte_in.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (byte_in.ready)
			valid_s1 <= byte_in.valid;
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid)
			item_s1 <= byte_in.payload;
	end

	always_comb begin
		step.step      = fire_s1;
		step.data_byte = item_s1.data_byte;
		step.last_byte = item_s1.last_byte;
	end

	ffcb_frame #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.payload_length(length_q),
		.frame_nxt     (frame_nxt)
	);

	assign csum = {frame_nxt.second_sum, frame_nxt.first_sum} + offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			seq_q       <= '0;
		end else if (fire_s1 && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
			if (item_s1.command == ffcb_pkg::CMD_BUILD)
				seq_q <= seq_q + 8'd1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && item_s1.last_byte) begin
			out_q.checksum <= csum;
			if (item_s1.command == ffcb_pkg::CMD_BUILD) begin
				out_q.match           <= 1'b0;
				out_q.sequence_number <= seq_q;
				out_q.length_byte     <= length_q;
			end else begin
				out_q.match           <= (frame_nxt.header_word == csum);
				out_q.sequence_number <= '0;
				out_q.length_byte     <= '0;
			end
		end
	end

	assign result_out.valid   = out_valid_q;
	assign result_out.payload = out_q;

	// sequence advances by one with each build result
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.last_byte && item_s1.command == ffcb_pkg::CMD_BUILD
		|=> seq_q == $past(seq_q) + 8'd1)
		else $error("sequence count did not advance on build");

	// frame state is back at byte 0 after a last word
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.last_byte |=> frame_nxt.position == ffcb_pkg::POS_W'(1))
		else $error("frame position not cleared after last word");

	// a last word never overwrites a pending result
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_out.ready |=> out_valid_q && $stable(out_q))
		else $error("pending result overwritten");

	// running sums stay reduced mod 255
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_nxt.first_sum != 8'hFF && frame_nxt.second_sum != 8'hFF)
		else $error("running sum out of range");

endmodule

FILE: bench/fletcher_frame_monitor.sv
`timescale 1ns / 1ps

module fletcher_frame_monitor #(
	parameter int HEADER_BYTES = ffcb_pkg::HEADER_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ffcb_in_if   byte_in,
	ffcb_out_if  result_out,
	ffcb_cfg_if  cfg,
	output int   fail_count,
	output int   outstanding
);

	logic [15:0]         offset_reg;
	logic [7:0]          plen_reg;
	logic [7:0]          sum_lo;
	logic [7:0]          sum_hi;
	logic [8:0]          position;
	logic [15:0]         header_word;
	logic [7:0]          seq_count;
	int                  errors;
	ffcb_pkg::out_word_t expected_results [$];

	function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 9'd255)
			s = s - 9'd255;
		return s[7:0];
	endfunction

	task automatic frame_step(input ffcb_pkg::in_word_t w);
		ffcb_pkg::out_word_t r;
		logic [15:0]         csum;
		if (position == 9'd0)
			header_word[7:0] = w.data_byte;
		else if (position == 9'd1)
			header_word[15:8] = w.data_byte;
		// payload window, never at the saturated position
		if (position >= HEADER_BYTES && position != ffcb_pkg::POS_MAX &&
				int'(position) < HEADER_BYTES + int'(plen_reg)) begin
			sum_lo = add_mod255(sum_lo, w.data_byte);
			sum_hi = add_mod255(sum_hi, sum_lo);
		end
		if (position != ffcb_pkg::POS_MAX)
			position = position + 9'd1;
		if (w.last_byte) begin
			csum = {sum_hi, sum_lo} + offset_reg;
			r = '0;
			r.checksum = csum;
			if (w.command == ffcb_pkg::CMD_CHECK) begin
				r.match = (header_word == csum);
			end else begin
				r.sequence_number = seq_count;
				r.length_byte = plen_reg;
				seq_count = seq_count + 8'd1;
			end
			expected_results.push_back(r);
			sum_lo = '0;
			sum_hi = '0;
			position = '0;
			header_word = '0;
		end
	endtask

	task automatic check_result(input ffcb_pkg::out_word_t got);
		ffcb_pkg::out_word_t want;
		if (expected_results.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: unexpected result: match %0d csum %h seq %h len %h",
					$realtime, got.match, got.checksum, got.sequence_number,
					got.length_byte);
		end else begin
			want = expected_results.pop_front();
			if (got.match !== want.match || got.checksum !== want.checksum ||
					got.sequence_number !== want.sequence_number ||
					got.length_byte !== want.length_byte) begin
				errors++;
				if (errors <= 10)
					$display("%0t: exp m %0d c %h s %h l %h, got m %0d c %h s %h l %h",
						$realtime, want.match, want.checksum, want.sequence_number,
						want.length_byte, got.match, got.checksum, got.sequence_number,
						got.length_byte);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_reg = '0;
			plen_reg = '0;
			sum_lo = '0;
			sum_hi = '0;
			position = '0;
			header_word = '0;
			seq_count = '0;
			errors = 0;
			expected_results.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// a result taken now belongs to an earlier last word, so retire first
			if (result_out.valid && result_out.ready)
				check_result(result_out.payload);
			if (cfg.valid && cfg.ready) begin
				case (cfg.payload.index)
					ffcb_pkg::REG_CHECKSUM_OFFSET: offset_reg = cfg.payload.data;
					ffcb_pkg::REG_PAYLOAD_LENGTH:  plen_reg = cfg.payload.data[7:0];
					default: ;
				endcase
			end
			if (byte_in.valid && byte_in.ready)
				frame_step(byte_in.payload);
			fail_count <= errors;
			outstanding <= expected_results.size();
		end
	end

endmodule

FILE: bench/frame_fletcher_check_build_top_tb.sv
`timescale 1ns / 1ps

module frame_fletcher_check_build_top_tb;

	localparam int HB = ffcb_pkg::HEADER_BYTES_DEF;
	localparam int HOLD_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	int          idle_pct;
	int          stall_pct;
	int          hold_reqs;
	int          bytes_sent;
	int          fail_count;
	int          outstanding;
	logic [15:0] cur_offset;
	logic [7:0]  cur_plen;
	logic [7:0]  frame_buf [0:599];

	ffcb_in_if  byte_in ();
	ffcb_out_if result_out ();
	ffcb_cfg_if cfg ();

	frame_fletcher_check_build_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_in),
		.result_out (result_out),
		.cfg        (cfg)
	);

	fletcher_frame_monitor #(.HEADER_BYTES(HB)) frame_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_in     (byte_in),
		.result_out  (result_out),
		.cfg         (cfg),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("frame_fletcher_check_build_top_tb failed");
		$finish;
	end

	// result side: random stalls, plus one long hold-off per request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_out.ready <= 1'b0;
				hold_left--;
			end else if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
				result_out.ready <= 1'b0;
			end else begin
				result_out.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic push_byte(input ffcb_pkg::cmd_t c, input logic [7:0] d, input logic l);
		bit ok;
		while ($urandom_range(99) < idle_pct) begin
			byte_in.valid <= 1'b0;
			@(posedge clk);
		end
		byte_in.valid <= 1'b1;
		byte_in.payload <= '{command: c, data_byte: d, last_byte: l};
		do begin
			@(negedge clk);
			ok = byte_in.ready;
			@(posedge clk);
		end while (!ok);
		bytes_sent++;
	endtask

	task automatic write_reg(input ffcb_pkg::reg_idx_t idx, input logic [15:0] v);
		bit ok;
		cfg.valid <= 1'b1;
		cfg.payload <= '{index: idx, data: v};
		do begin
			@(negedge clk);
			ok = cfg.ready;
			@(posedge clk);
		end while (!ok);
	endtask

	// drain, let the pipeline empty, then write both registers
	task automatic reconfigure(input logic [15:0] off, input logic [7:0] plen);
		byte_in.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
		write_reg(ffcb_pkg::REG_CHECKSUM_OFFSET, off);
		write_reg(ffcb_pkg::REG_PAYLOAD_LENGTH, {8'($urandom), plen});
		cfg.valid <= 1'b0;
		cur_offset = off;
		cur_plen = plen;
	endtask

	// random frame; with good set the header carries the right checksum
	task automatic send_frame(input ffcb_pkg::cmd_t c, input int n, input bit good);
		logic [7:0]  s1;
		logic [7:0]  s2;
		logic [8:0]  t;
		logic [15:0] sum;
		for (int i = 0; i < n; i++)
			frame_buf[i] = 8'($urandom);
		if (good) begin
			s1 = '0;
			s2 = '0;
			for (int i = HB; i < n && i < HB + int'(cur_plen); i++) begin
				t = {1'b0, s1} + {1'b0, frame_buf[i]};
				if (t >= 9'd255)
					t = t - 9'd255;
				s1 = t[7:0];
				t = {1'b0, s2} + {1'b0, s1};
				if (t >= 9'd255)
					t = t - 9'd255;
				s2 = t[7:0];
			end
			sum = {s2, s1} + cur_offset;
			if (n > 0)
				frame_buf[0] = sum[7:0];
			if (n > 1)
				frame_buf[1] = sum[15:8];
		end
		// only the command on the last word counts
		for (int i = 0; i < n; i++)
			push_byte((i == n - 1) ? c : ffcb_pkg::cmd_t'($urandom_range(1)),
				frame_buf[i], i == n - 1);
	endtask

	function automatic int fit_len(input int limit);
		return (HB + int'(cur_plen) + 3 > limit) ? limit : HB + int'(cur_plen) + 3;
	endfunction

	task automatic random_frames(input int budget, input int max_len);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < budget)
			send_frame(ffcb_pkg::cmd_t'($urandom_range(1)), $urandom_range(max_len, 1),
				$urandom_range(99) < 75);
	endtask

	initial begin
		int wait_cnt;
		arst_n <= 1'b0;
		byte_in.valid <= 1'b0;
		byte_in.payload <= '0;
		cfg.valid <= 1'b0;
		cfg.payload <= '0;
		idle_pct = 0;
		stall_pct <= 0;
		hold_reqs <= 0;
		bytes_sent = 0;
		cur_offset = '0;
		cur_plen = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: one-word frames, header word is the byte itself
		push_byte(ffcb_pkg::CMD_CHECK, 8'h00, 1'b1);
		push_byte(ffcb_pkg::CMD_BUILD, 8'hFF, 1'b1);

		// extremes; short frames end inside the payload
		reconfigure(16'hFFFF, 8'd255);
		push_byte(ffcb_pkg::CMD_BUILD, 8'hFF, 1'b0);
		push_byte(ffcb_pkg::CMD_CHECK, 8'hFF, 1'b0);
		push_byte(ffcb_pkg::CMD_BUILD, 8'h00, 1'b0);
		push_byte(ffcb_pkg::CMD_CHECK, 8'hFF, 1'b0);
		push_byte(ffcb_pkg::CMD_BUILD, 8'hFF, 1'b0);
		push_byte(ffcb_pkg::CMD_CHECK, 8'h00, 1'b1);
		push_byte(ffcb_pkg::CMD_CHECK, 8'h00, 1'b0);
		push_byte(ffcb_pkg::CMD_CHECK, 8'hFF, 1'b0);
		push_byte(ffcb_pkg::CMD_CHECK, 8'h00, 1'b0);
		push_byte(ffcb_pkg::CMD_CHECK, 8'hFF, 1'b0);
		push_byte(ffcb_pkg::CMD_BUILD, 8'h80, 1'b1);

		// bytes past the payload ignored, bad header word
		reconfigure(16'h0001, 8'd2);
		push_byte(ffcb_pkg::CMD_BUILD, 8'h12, 1'b0);
		push_byte(ffcb_pkg::CMD_BUILD, 8'h34, 1'b0);
		push_byte(ffcb_pkg::CMD_CHECK, 8'h56, 1'b0);
		push_byte(ffcb_pkg::CMD_BUILD, 8'h78, 1'b0);
		push_byte(ffcb_pkg::CMD_CHECK, 8'h01, 1'b0);
		push_byte(ffcb_pkg::CMD_BUILD, 8'hFE, 1'b0);
		push_byte(ffcb_pkg::CMD_BUILD, 8'hAA, 1'b0);
		push_byte(ffcb_pkg::CMD_CHECK, 8'h55, 1'b1);

		reconfigure(16'($urandom), 8'($urandom_range(8)));
		random_frames(25, fit_len(24));

		// full payload and a frame long enough to saturate the position
		idle_pct = 69;
		reconfigure(16'h0000, 8'd255);
		send_frame(ffcb_pkg::CMD_CHECK, 530, 1'b1);
		random_frames(15, 24);

		idle_pct = 0;
		stall_pct <= 69;
		reconfigure(16'($urandom), 8'($urandom_range(8)));
		random_frames(30, fit_len(24));

		idle_pct = 9;
		stall_pct <= 9;
		reconfigure(16'hFFFF, 8'd1);
		random_frames(30, fit_len(24));

		// long hold-off on results with short frames, so input backs up
		idle_pct = 0;
		stall_pct <= 0;
		reconfigure(16'($urandom), 8'd0);
		hold_reqs <= hold_reqs + 1;
		random_frames(40, 3);

		idle_pct = 9;
		stall_pct <= 69;
		reconfigure(16'($urandom), 8'($urandom_range(12)));
		random_frames(30, fit_len(24));

		byte_in.valid <= 1'b0;
		for (wait_cnt = 0; wait_cnt < 5000 && outstanding != 0; wait_cnt++)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("frame_fletcher_check_build_top_tb passed");
		end else begin
			$display("frame_fletcher_check_build_top_tb failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
design/ffcb_pkg.sv
design/ffcb_if.sv
design/ffcb_frame.sv
design/frame_fletcher_check_build_top.sv
bench/fletcher_frame_monitor.sv
bench/frame_fletcher_check_build_top_tb.sv
